// File: hw/rtl/bli_pkg.sv
// Shared types and codes for the bounded list block.
// Used by the sequencer, the output stage and the top level; depends on nothing.
package bli_pkg;

    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 2;
    localparam int MAX_EMIT = 32;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE     = 2'd2;

    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic signed [VALUE_W-1:0] item_value;
        logic [POS_W-1:0]          item_position;
        logic                      is_last;
        logic                      list_empty;
        logic [STAT_W-1:0]         status;
    } t_beat;

endpackage

// File: hw/rtl/bounded_list_insert_delete.sv
// Bounded ordered list of signed 32-bit values with push front, push back and
// delete at position. Each input beat carries a command in s_axis_tuser and an
// operand in s_axis_tdata; after every command the block streams the whole list
// in order, one beat per entry, tlast on the final one (at most 32 beats). An
// empty list gives a single beat flagged empty with value 0. A push into a full
// list is dropped with status 2; a delete whose position is negative or at or
// beyond the count is ignored with status 1; the status repeats on every beat
// of the listing. Entries live in one RAM of CAPACITY words as a circular
// buffer with a front pointer. Each command is accepted and then applied; a
// delete then shifts any later entries forward through the RAM, and the
// listing streams one beat per cycle from the RAM read port while the output
// side accepts beats. The RAM read port is the bottleneck for both the shift
// and the listing. A new command is taken once the listing has been handed to
// the output register, while its last beat may still wait there. Depends on
// bli_pkg, bli_seq, bli_out.
module bounded_list_insert_delete #(
    parameter int CAPACITY = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] operand
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] item_value, [36:32] item_position, pad
    output logic        m_axis_tlast,   // is_last
    output logic [2:0]  m_axis_tuser    // [0] list_empty, [2:1] status
);

    logic           beat_valid;
    logic           beat_ready;
    bli_pkg::t_beat beat;

    // command decode, list state and RAM traffic
    bli_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_cmd        (s_axis_tuser),
        .i_opnd       (s_axis_tdata),
        .o_beat_valid (beat_valid),
        .o_beat       (beat),
        .i_beat_ready (beat_ready)
    );

    // hold each result beat until downstream takes it
    bli_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat_valid (beat_valid),
        .i_beat       (beat),
        .o_beat_ready (beat_ready),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_tdata      (m_axis_tdata),
        .o_tlast      (m_axis_tlast),
        .o_tuser      (m_axis_tuser)
    );

endmodule

// File: hw/rtl/bli_ram.sv
// Generic single-write, single-read RAM with registered, enable-held read data.
// Stand-alone; no package dependencies.
module bli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/bli_seq.sv
// Command sequencer: list bookkeeping, delete shifting and listing reads.
// Depends on bli_pkg and bli_ram.
module bli_seq #(
    parameter int CAPACITY = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [bli_pkg::CMD_W-1:0]        i_cmd,
    input  logic signed [bli_pkg::VALUE_W-1:0] i_opnd,
    output logic                             o_beat_valid,
    output bli_pkg::t_beat                   o_beat,
    input  logic                             i_beat_ready
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;
    localparam int EMIT_LIM = (CAPACITY < bli_pkg::MAX_EMIT) ? CAPACITY : bli_pkg::MAX_EMIT;
    localparam logic [CW-1:0] EMIT_N = CW'(EMIT_LIM);
    localparam logic [CW-1:0] CAP_N  = CW'(CAPACITY);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_LIST  = 2'd3;

    function automatic logic [IW-1:0] f_slot(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(CAPACITY)) begin
            sum = sum - SW'(CAPACITY);
        end
        return IW'(sum);
    endfunction

    logic [1:0]                    r_state, n_state;
    logic [bli_pkg::CMD_W-1:0]     r_cmd, n_cmd;
    logic [bli_pkg::VALUE_W-1:0]   r_opnd, n_opnd;
    logic [IW-1:0]                 r_front, n_front;
    logic [CW-1:0]                 r_count, n_count;
    logic [bli_pkg::STAT_W-1:0]    r_status, n_status;
    logic [CW-1:0]                 r_pos, n_pos;
    logic [CW-1:0]                 r_wpos, n_wpos;
    logic                          r_pend, n_pend;
    logic                          r_lv, n_lv;
    logic [bli_pkg::POS_W-1:0]     r_apos, n_apos;
    logic                          r_alast, n_alast;

    logic                          we, re;
    logic [IW-1:0]                 waddr, raddr;
    logic [bli_pkg::VALUE_W-1:0]   wdata, rdata;
    logic                          full, del_ok, b_load, a_free;
    logic [CW-1:0]                 emit_n;

    bli_ram #(
        .WIDTH (bli_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign full   = (r_count == CAP_N);
    assign del_ok = !r_opnd[bli_pkg::VALUE_W-1] && (r_opnd < 32'(r_count));
    assign emit_n = (r_count > EMIT_N) ? EMIT_N : r_count;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_beat_valid = r_lv || ((r_state == S_LIST) && (r_count == '0));
    assign b_load       = o_beat_valid && i_beat_ready;
    assign a_free       = !r_lv || b_load;

    always_comb begin
        if (r_lv) begin
            o_beat.item_value    = rdata;
            o_beat.item_position = r_apos;
            o_beat.is_last       = r_alast;
            o_beat.list_empty    = 1'b0;
        end else begin
            o_beat.item_value    = '0;
            o_beat.item_position = '0;
            o_beat.is_last       = 1'b1;
            o_beat.list_empty    = 1'b1;
        end
        o_beat.status = r_status;
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_opnd   = r_opnd;
        n_front  = r_front;
        n_count  = r_count;
        n_status = r_status;
        n_pos    = r_pos;
        n_wpos   = r_wpos;
        n_pend   = r_pend;
        n_lv     = r_lv;
        n_apos   = r_apos;
        n_alast  = r_alast;
        we       = 1'b0;
        re       = 1'b0;
        waddr    = f_slot(r_front, r_wpos);
        raddr    = f_slot(r_front, r_pos);
        wdata    = r_opnd;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_cmd;
                    n_opnd  = i_opnd;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status = bli_pkg::STAT_DONE;
                n_state  = S_LIST;
                n_pos    = '0;
                unique case (r_cmd) inside
                    bli_pkg::CMD_PUSH_FRONT, bli_pkg::CMD_PUSH_BACK: begin
                        if (full) begin
                            n_status = bli_pkg::STAT_FULL;
                        end else begin
                            we      = 1'b1;
                            n_count = r_count + CW'(1);
                            if (r_cmd == bli_pkg::CMD_PUSH_FRONT) begin
                                n_front = (r_front == '0) ? IW'(CAPACITY - 1)
                                                          : r_front - IW'(1);
                                waddr   = n_front;
                            end else begin
                                waddr = f_slot(r_front, r_count);
                            end
                        end
                    end
                    bli_pkg::CMD_DELETE: begin
                        if (!del_ok) begin
                            n_status = bli_pkg::STAT_RANGE;
                        end else begin
                            n_wpos  = CW'(r_opnd);
                            n_pos   = CW'(r_opnd) + CW'(1);
                            n_pend  = 1'b0;
                            n_state = S_SHIFT;
                        end
                    end
                    default: begin
                        // unused command: leave the list as it is
                    end
                endcase
            end
            S_SHIFT: begin
                // move each later entry one place toward the front
                if (r_pend) begin
                    we     = 1'b1;
                    wdata  = rdata;
                    n_wpos = r_wpos + CW'(1);
                end
                if (r_pos < r_count) begin
                    re     = 1'b1;
                    n_pos  = r_pos + CW'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_count = r_count - CW'(1);
                        n_pos   = '0;
                        n_state = S_LIST;
                    end
                end
            end
            S_LIST: begin
                if (r_count == '0) begin
                    if (b_load) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    if (r_pos < emit_n && a_free) begin
                        re      = 1'b1;
                        n_lv    = 1'b1;
                        n_apos  = bli_pkg::POS_W'(r_pos);
                        n_alast = ((r_pos + CW'(1)) == emit_n);
                        n_pos   = r_pos + CW'(1);
                    end else if (b_load) begin
                        n_lv = 1'b0;
                    end
                    if (r_pos == emit_n && a_free) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_front  <= '0;
            r_count  <= '0;
            r_status <= bli_pkg::STAT_DONE;
            r_pos    <= '0;
            r_wpos   <= '0;
            r_pend   <= 1'b0;
            r_lv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_front  <= n_front;
            r_count  <= n_count;
            r_status <= n_status;
            r_pos    <= n_pos;
            r_wpos   <= n_wpos;
            r_pend   <= n_pend;
            r_lv     <= n_lv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_opnd  <= n_opnd;
        r_apos  <= n_apos;
        r_alast <= n_alast;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_N)
        else $error("entry count above capacity");

    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SW'(r_front) < SW'(CAPACITY))
        else $error("front index outside store");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_lv && !r_pend))
        else $error("pipeline not drained at idle");

    a_shift_no_alias: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_pend && r_pos < r_count) |-> (waddr != raddr))
        else $error("shift reads and writes the same entry");

    a_list_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST && n_state == S_IDLE) |-> b_load)
        else $error("listing ended without handing off its final beat");

endmodule

// File: hw/rtl/bli_out.sv
// Output register for result beats, decoupling the sequencer from downstream stalls.
// Depends on bli_pkg.
module bli_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_beat_valid,
    input  bli_pkg::t_beat      i_beat,
    output logic                o_beat_ready,
    output logic                o_tvalid,
    input  logic                i_tready,
    output logic [39:0]         o_tdata,
    output logic                o_tlast,
    output logic [2:0]          o_tuser
);

    logic           r_valid;
    bli_pkg::t_beat r_beat;

    assign o_beat_ready = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_beat_ready) begin
            r_valid <= i_beat_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_beat_ready && i_beat_valid) begin
            r_beat <= i_beat;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {3'b000, r_beat.item_position, r_beat.item_value};
    assign o_tlast  = r_beat.is_last;
    assign o_tuser  = {r_beat.status, r_beat.list_empty};

endmodule

// File: tb/sv/bounded_list_insert_delete_test.sv
// Self-checking testbench for bounded_list_insert_delete: streams list commands, rebuilds
// each expected listing from an ordered queue, and compares every output beat in order.
// Depends on bli_pkg and the bounded_list_insert_delete RTL.
module bounded_list_insert_delete_test;

    localparam int LIST_CAP     = 32;
    localparam int PHASE_ITEMS  = 160;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 80;
    localparam int REPORT_MAX   = 10;

    // command code the block leaves undefined: list unchanged, listing repeated
    localparam logic [bli_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef enum int {EP_GROW, EP_MIX_A, EP_SHRINK, EP_MIX_B} t_episode;

    // Ordered copy of the list plus the listing beats still owed by the block.
    class list_scoreboard;
        logic [bli_pkg::VALUE_W-1:0] list_values[$];
        bli_pkg::t_beat              listing_beats[$];
        int                          mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int count();
            return list_values.size();
        endfunction

        function int pending();
            return listing_beats.size();
        endfunction

        // Apply one accepted command and queue the listing it produces.
        function void note_command(logic [bli_pkg::CMD_W-1:0] cmd,
                                   logic [bli_pkg::VALUE_W-1:0] opnd);
            logic [bli_pkg::STAT_W-1:0] stat;
            bli_pkg::t_beat             b;
            int                         n;
            stat = bli_pkg::STAT_DONE;
            case (cmd) inside
                bli_pkg::CMD_PUSH_FRONT, bli_pkg::CMD_PUSH_BACK: begin
                    if (list_values.size() >= LIST_CAP)
                        stat = bli_pkg::STAT_FULL;
                    else if (cmd == bli_pkg::CMD_PUSH_FRONT)
                        list_values.push_front(opnd);
                    else
                        list_values.push_back(opnd);
                end
                bli_pkg::CMD_DELETE: begin
                    // negative positions have the sign bit set and are out of range
                    if (opnd[bli_pkg::VALUE_W-1] || opnd >= list_values.size())
                        stat = bli_pkg::STAT_RANGE;
                    else
                        list_values.delete(int'(opnd));
                end
                default: ;
            endcase
            b = '0;
            b.status = stat;
            if (list_values.size() == 0) begin
                b.is_last    = 1'b1;
                b.list_empty = 1'b1;
                listing_beats.push_back(b);
            end else begin
                n = (list_values.size() < bli_pkg::MAX_EMIT) ? list_values.size()
                                                             : bli_pkg::MAX_EMIT;
                for (int i = 0; i < n; i++) begin
                    b.item_value    = list_values[i];
                    b.item_position = bli_pkg::POS_W'(i);
                    b.is_last       = (i == n - 1);
                    listing_beats.push_back(b);
                end
            end
        endfunction

        // Compare one output beat against the oldest owed beat.
        function void check_beat(bli_pkg::t_beat got);
            bli_pkg::t_beat want;
            bit             bad;
            if (listing_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected beat: value %h pos %0d last %0b empty %0b status %0d",
                             got.item_value, got.item_position, got.is_last,
                             got.list_empty, got.status);
                return;
            end
            want = listing_beats.pop_front();
            bad  = (got.item_value !== want.item_value)
                || (got.item_position !== want.item_position)
                || (got.is_last !== want.is_last)
                || (got.list_empty !== want.list_empty)
                || (got.status !== want.status);
            if (bad) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("beat mismatch at %0t", $realtime);
                    $display("  expected: value %h pos %0d last %0b empty %0b status %0d",
                             want.item_value, want.item_position, want.is_last,
                             want.list_empty, want.status);
                    $display("  actual:   value %h pos %0d last %0b empty %0b status %0d",
                             got.item_value, got.item_position, got.is_last,
                             got.list_empty, got.status);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // [31:0] operand
    logic [1:0]  s_axis_tuser = '0;    // [1:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // [31:0] item_value, [36:32] item_position, pad
    logic        m_axis_tlast;         // is_last
    logic [2:0]  m_axis_tuser;         // [0] list_empty, [2:1] status

    list_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int items_sent    = 0;
    int stall_cycles  = 0;

    bounded_list_insert_delete #(.CAPACITY(LIST_CAP)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: during a hold-off keep tready low for the whole stretch so the list
    // backs up into the input side; otherwise drop tready at the phase's idle rate.
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Monitor: every accepted output beat goes straight to the scoreboard.
    always @(posedge i_clk) begin
        bli_pkg::t_beat got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.item_value    = m_axis_tdata[31:0];
            got.item_position = m_axis_tdata[36:32];
            got.is_last       = m_axis_tlast;
            got.list_empty    = m_axis_tuser[0];
            got.status        = m_axis_tuser[2:1];
            sb.check_beat(got);
        end
    end

    // Watchdog: end the run if neither side moves a beat for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Offer one command beat; idle first at the phase's rate, then hold it until taken.
    task automatic send_command(input logic [bli_pkg::CMD_W-1:0] cmd,
                                input logic [31:0] opnd);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= opnd;
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_command(cmd, opnd);
        items_sent++;
    endtask

    // Drop tvalid and hold off until every owed listing beat has arrived.
    task automatic pause_sender();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    // Push value: mostly random bits, sometimes a signed extreme, zero or all ones.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Valid delete position, biased toward the head and the tail.
    function automatic logic [31:0] pick_position();
        int n;
        n = sb.count();
        case ($urandom_range(0, 3))
            0:       return 32'd0;
            1:       return 32'(n - 1);
            default: return 32'($urandom_range(0, n - 1));
        endcase
    endfunction

    task automatic push_random();
        send_command($urandom_range(0, 1) ? bli_pkg::CMD_PUSH_BACK : bli_pkg::CMD_PUSH_FRONT,
                     pick_value());
    endtask

    // Fill the list to capacity, then push a few more into the full list.
    task automatic grow_list();
        int guard;
        int r;
        guard = 0;
        while (sb.count() < LIST_CAP && guard < 80) begin
            r = $urandom_range(0, 99);
            if (r < 80 || sb.count() == 0)
                push_random();
            else if (r < 92)
                send_command(bli_pkg::CMD_DELETE, pick_position());
            else
                send_command(bli_pkg::CMD_DELETE, 32'(sb.count() + $urandom_range(0, 3)));
            guard++;
        end
        repeat ($urandom_range(1, 3)) push_random();
    endtask

    // Drain the list by deletes, with some rejected positions, then delete on empty.
    task automatic shrink_list();
        int guard;
        int r;
        guard = 0;
        while (sb.count() > 0 && guard < 80) begin
            r = $urandom_range(0, 99);
            if (r < 85)
                send_command(bli_pkg::CMD_DELETE, pick_position());
            else if (r < 93)
                send_command(bli_pkg::CMD_DELETE, 32'(sb.count()));
            else
                send_command(bli_pkg::CMD_DELETE, $urandom | 32'h8000_0000);
            guard++;
        end
        send_command(bli_pkg::CMD_DELETE, 32'($urandom_range(0, 2)));
    endtask

    // Mixed traffic around the current fill level.
    task automatic mix_list();
        int r;
        repeat (20) begin
            r = $urandom_range(0, 99);
            if (r < 50)
                push_random();
            else if (r < 80 && sb.count() > 0)
                send_command(bli_pkg::CMD_DELETE, pick_position());
            else if (r < 90)
                send_command(bli_pkg::CMD_DELETE, $urandom);
            else if (r < 95)
                send_command(CMD_UNUSED, $urandom);
            else
                send_command(bli_pkg::CMD_DELETE, 32'(sb.count()));
        end
    endtask

    initial begin
        t_episode ep;

        // hold reset, then release it between edges
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        ep = EP_GROW;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 11; recv_idle_pct = 55; end
                1: begin send_idle_pct = 55; recv_idle_pct = 11; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase

            if (phase == 0) begin
                // empty list: rejected delete and the unused command
                send_command(bli_pkg::CMD_DELETE, 32'd0);
                send_command(CMD_UNUSED, 32'h1234_5678);
                // build six entries from both ends with extreme and alternating bits
                send_command(bli_pkg::CMD_PUSH_BACK,  32'h7FFF_FFFF);
                send_command(bli_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
                send_command(bli_pkg::CMD_PUSH_BACK,  32'h0000_0000);
                send_command(bli_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF);
                send_command(bli_pkg::CMD_PUSH_BACK,  32'h5555_5555);
                send_command(bli_pkg::CMD_PUSH_FRONT, 32'hAAAA_AAAA);
                // rejected deletes: negative, most negative, one past the end, huge
                send_command(bli_pkg::CMD_DELETE, 32'hFFFF_FFFF);
                send_command(bli_pkg::CMD_DELETE, 32'h8000_0000);
                send_command(bli_pkg::CMD_DELETE, 32'd6);
                send_command(bli_pkg::CMD_DELETE, 32'h7FFF_FFFF);
                send_command(CMD_UNUSED, 32'hFFFF_FFFF);
                // middle, tail and head deletes, then empty the list
                send_command(bli_pkg::CMD_DELETE, 32'd2);
                send_command(bli_pkg::CMD_DELETE, 32'd4);
                send_command(bli_pkg::CMD_DELETE, 32'd0);
                send_command(bli_pkg::CMD_DELETE, 32'd1);
                send_command(bli_pkg::CMD_DELETE, 32'd1);
                send_command(bli_pkg::CMD_DELETE, 32'd0);
                send_command(CMD_UNUSED, 32'd0);
                // long receiver hold-off while the sender keeps offering
                hold_left = HOLD_CYCLES;
            end

            while (items_sent < (phase + 1) * PHASE_ITEMS) begin
                case (ep)
                    EP_GROW:   grow_list();
                    EP_SHRINK: shrink_list();
                    default:   mix_list();
                endcase
                ep = (ep == EP_MIX_B) ? EP_GROW : t_episode'(ep + 1);
            end

            // sender pauses until the block has delivered everything
            pause_sender();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.pending() > 0)
            $display("%0d expected beats never arrived", sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
